/* hdl/lssg_pkg.sv */
package lssg_pkg;

   // Fixed-point formats.
   localparam int FRAC_BITS  = 8;
   localparam int TEMP_FRAC  = 8;
   localparam int QUEUE_KNEE = 50;
   localparam int PCT_W      = 15;
   localparam int FLOOR_W    = 14;
   localparam int WEIGHT_W   = 16;
   localparam int QUEUE_W    = 10;
   localparam int TEMP_W     = 16;
   localparam int BAT_W      = 18;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_KNEE);

   localparam logic [PCT_W-1:0]   FULL_PCT  = PCT_W'(100 << FRAC_BITS);
   localparam logic [FLOOR_W-1:0] HALF_PCT  = FLOOR_W'((100 << FRAC_BITS) >> 1);
   localparam logic [PCT_W-1:0]   RAMP_LO   = PCT_W'(30 << FRAC_BITS);
   localparam logic [PCT_W-1:0]   RAMP_HI   = PCT_W'(70 << FRAC_BITS);
   localparam logic [TEMP_W-1:0]  THERM_BASE = TEMP_W'(60 << TEMP_FRAC);

   // Battery drain: |power| / 250 percent, evaluated as a reciprocal multiply.
   localparam int BAT_X_W = 23;
   localparam logic [BAT_W-1:0]   BAT_SAT_MAG = BAT_W'(25000);
   localparam logic [BAT_X_W-1:0] BAT_ROUND   = BAT_X_W'(125);
   localparam logic [BAT_X_W-1:0] BAT_DIV     = BAT_X_W'(250);
   localparam logic [47:0]        BAT_RECIP   = 48'd17179869;

   // Memory and battery share one fixed weight.
   localparam logic [27:0] MIX_WEIGHT = 28'd3277;

   // Poll interval scaling: divide by 100 after dropping the fraction bits.
   localparam int IV_W     = 16;
   localparam int IV_NUM_W = 23;
   localparam logic [IV_NUM_W-1:0] INTERVAL_DIV = IV_NUM_W'(100);
   localparam logic [48:0]         RECIP_100    = 49'd42949672;

   localparam int NUM_STAGES = 8;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WEIGHT_CPU     = 3'd0,
      REG_WEIGHT_QUEUE   = 3'd1,
      REG_WEIGHT_THERMAL = 3'd2,
      REG_WEIGHT_GPU     = 3'd3,
      REG_WEIGHT_DISK    = 3'd4,
      REG_INTERVAL_MIN   = 3'd5,
      REG_INTERVAL_MAX   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight_cpu;
      logic [WEIGHT_W-1:0] weight_queue;
      logic [WEIGHT_W-1:0] weight_thermal;
      logic [WEIGHT_W-1:0] weight_gpu;
      logic [WEIGHT_W-1:0] weight_disk;
      logic [IV_W-1:0]     interval_min_ms;
      logic [IV_W-1:0]     interval_max_ms;
   } csr_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [PCT_W-1:0]  cpu_util;
      logic [QUEUE_W-1:0] queue_length;
      logic [TEMP_W-1:0] temperature;
      logic [PCT_W-1:0]  gpu_util;
      logic [PCT_W-1:0]  disk_util;
      logic [PCT_W-1:0]  ram_util;
      logic [BAT_W-1:0]  battery_power;
   } sample_type;

   typedef struct packed {
      logic [30:0]        prod_cpu;
      logic [30:0]        prod_queue;
      logic [30:0]        prod_thermal;
      logic [30:0]        prod_gpu;
      logic [30:0]        prod_disk;
      logic [PCT_W-1:0]   ram;
      logic [PCT_W-1:0]   bat_q0;
      logic [BAT_X_W-1:0] bat_x;
      logic               bat_neg;
      logic               bat_sat;
   } products_type;

   typedef struct packed {
      logic [PCT_W-1:0]   stress;
      logic [IV_W-1:0]    poll_interval_ms;
      logic [PCT_W-1:0]   perf_boost;
      logic [FLOOR_W-1:0] cpu_floor;
   } result_type;

   typedef logic [QUEUE_KNEE-1:0][PCT_W-1:0] queue_table_type;

   function automatic logic [PCT_W-1:0] sat_pct(input logic [18:0] v);
      return (v > 19'(FULL_PCT)) ? FULL_PCT : v[PCT_W-1:0];
   endfunction

   // log2 of x as unsigned Q.24 by repeated squaring, truncating.
   function automatic logic [63:0] log2_q24(input logic [31:0] x);
      logic [63:0] y;
      logic [63:0] frac;
      int          n;
      n    = 0;
      frac = '0;
      for (int i = 0; i < 31; i++) begin
         if ((x >> (i + 1)) != 32'd0) begin
            n = i + 1;
         end
      end
      y = (64'(x) << 30) >> n;
      for (int k = 0; k < 24; k++) begin
         y    = (y * y) >> 30;
         frac = frac << 1;
         if (y >= (64'd2 << 30)) begin
            y    = y >> 1;
            frac = frac | 64'd1;
         end
      end
      return (64'(n) << 24) | frac;
   endfunction

   // Queue term for every length below the knee, rounded to nearest.
   function automatic queue_table_type build_queue_table();
      queue_table_type tbl;
      logic [63:0]     den;
      logic [63:0]     num;
      logic [63:0]     rem;
      logic [63:0]     quo;
      den = log2_q24(32'(QUEUE_KNEE + 1));
      for (int q = 0; q < QUEUE_KNEE; q++) begin
         num = log2_q24(32'(q + 1)) * 64'(FULL_PCT) + (den >> 1);
         rem = '0;
         quo = '0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
               rem    = rem - den;
               quo[b] = 1'b1;
            end
         end
         tbl[q] = (quo > 64'(FULL_PCT)) ? FULL_PCT : quo[PCT_W-1:0];
      end
      return tbl;
   endfunction

   localparam queue_table_type QUEUE_TABLE = build_queue_table();

endpackage

/* hdl/lssg_terms.sv */
module lssg_terms import lssg_pkg::*; (
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  csr_type       csr,
   input  sample_type    sample,
   output products_type  prod_out
);

   // Stage 1: saturated percents and the nonlinear terms.
   logic [PCT_W-1:0]   cpu_ff, gpu_ff, disk_ff, ram_ff, queue_ff, therm_ff;
   logic [PCT_W-1:0]   queue_in, therm_in;
   logic [BAT_X_W-1:0] bat_x_ff, bat_x_in;
   logic               bat_neg_ff, bat_sat_ff, bat_sat_in;
   logic [TEMP_W-1:0]  therm_d;
   logic [17:0]        therm_x5;
   logic [17:0]        therm_half;
   logic [BAT_W-1:0]   bat_mag;

   always_comb begin
      if (sample.queue_length >= QUEUE_W'(QUEUE_KNEE)) begin
         queue_in = FULL_PCT;
      end else begin
         queue_in = QUEUE_TABLE[sample.queue_length[QUEUE_IDX_W-1:0]];
      end

      // 2.5 percent per degree above the base temperature.
      therm_d    = sample.temperature - THERM_BASE;
      therm_x5   = {therm_d, 2'b00} + 18'(therm_d);
      therm_half = 18'((19'(therm_x5) + 19'd1) >> 1);
      if (sample.temperature <= THERM_BASE) begin
         therm_in = '0;
      end else begin
         therm_in = sat_pct(19'(therm_half));
      end

      bat_mag    = ~sample.battery_power + BAT_W'(1);
      bat_sat_in = bat_mag >= BAT_SAT_MAG;
      bat_x_in   = {bat_mag[14:0], 8'h00} + BAT_ROUND;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         cpu_ff     <= sat_pct(19'(sample.cpu_util));
         gpu_ff     <= sat_pct(19'(sample.gpu_util));
         disk_ff    <= sat_pct(19'(sample.disk_util));
         ram_ff     <= sat_pct(19'(sample.ram_util));
         queue_ff   <= queue_in;
         therm_ff   <= therm_in;
         bat_x_ff   <= bat_x_in;
         bat_neg_ff <= sample.battery_power[BAT_W-1];
         bat_sat_ff <= bat_sat_in;
      end
   end

   // Stage 2: weighted products and the battery quotient estimate.
   products_type prod_ff, prod_in;
   logic [47:0]  bat_prod;

   always_comb begin
      bat_prod             = 48'(bat_x_ff) * BAT_RECIP;
      prod_in.prod_cpu     = 31'(cpu_ff)   * 31'(csr.weight_cpu);
      prod_in.prod_queue   = 31'(queue_ff) * 31'(csr.weight_queue);
      prod_in.prod_thermal = 31'(therm_ff) * 31'(csr.weight_thermal);
      prod_in.prod_gpu     = 31'(gpu_ff)   * 31'(csr.weight_gpu);
      prod_in.prod_disk    = 31'(disk_ff)  * 31'(csr.weight_disk);
      prod_in.ram          = ram_ff;
      prod_in.bat_q0       = bat_prod[32 +: PCT_W];
      prod_in.bat_x        = bat_x_ff;
      prod_in.bat_neg      = bat_neg_ff;
      prod_in.bat_sat      = bat_sat_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_out = prod_ff;

endmodule

/* hdl/lssg_score.sv */
module lssg_score import lssg_pkg::*; (
   input  logic             clock,
   input  pipe_ctrl_type    ctrl,
   input  products_type     prod,
   output logic [PCT_W-1:0] stress
);

   // Stage 3: battery quotient correction and the partial sum.
   logic [33:0]        psum_ff, psum_in;
   logic [PCT_W-1:0]   bat_ff, bat_in, ram_ff;
   logic [BAT_X_W-1:0] bat_r;

   always_comb begin
      bat_r = prod.bat_x - BAT_X_W'(prod.bat_q0) * BAT_DIV;
      if (!prod.bat_neg) begin
         bat_in = '0;
      end else if (prod.bat_sat) begin
         bat_in = FULL_PCT;
      end else begin
         bat_in = prod.bat_q0 + PCT_W'(bat_r >= BAT_DIV);
      end
      psum_in = 34'(prod.prod_cpu) + 34'(prod.prod_queue) + 34'(prod.prod_thermal)
              + 34'(prod.prod_gpu) + 34'(prod.prod_disk);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         psum_ff <= psum_in;
         bat_ff  <= bat_in;
         ram_ff  <= prod.ram;
      end
   end

   // Stage 4: memory plus battery drain at the shared weight.
   logic [33:0] psum4_ff;
   logic [27:0] mix_ff, mix_in;
   logic [15:0] ram_bat;

   always_comb begin
      ram_bat = 16'(ram_ff) + 16'(bat_ff);
      mix_in  = 28'(ram_bat) * MIX_WEIGHT;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         psum4_ff <= psum_ff;
         mix_ff   <= mix_in;
      end
   end

   // Stage 5: final sum, rounding shift and clamp.
   logic [34:0]      total;
   logic [18:0]      rounded;
   logic [PCT_W-1:0] stress_ff;

   always_comb begin
      total   = 35'(psum4_ff) + 35'(mix_ff);
      rounded = 19'((total + 35'd32768) >> 16);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         stress_ff <= sat_pct(rounded);
      end
   end

   assign stress = stress_ff;

endmodule

/* hdl/lssg_ramp.sv */
module lssg_ramp import lssg_pkg::*; (
   input  logic             clock,
   input  pipe_ctrl_type    ctrl,
   input  csr_type          csr,
   input  logic [PCT_W-1:0] stress,
   output result_type       result
);

   // Stage 6: interval product and the boost and floor ramp.
   logic               asc_in, asc6_ff;
   logic [IV_W-1:0]    diff;
   logic [30:0]        prod_ff, prod_in;
   logic [PCT_W-1:0]   stress6_ff, boost_in, boost6_ff, ramp_d;
   logic [FLOOR_W-1:0] floor_in, floor6_ff;
   logic [16:0]        ramp_x5;

   always_comb begin
      asc_in  = csr.interval_max_ms >= csr.interval_min_ms;
      diff    = asc_in ? (csr.interval_max_ms - csr.interval_min_ms)
                       : (csr.interval_min_ms - csr.interval_max_ms);
      prod_in = 31'(stress) * 31'(diff);
      ramp_d  = stress - RAMP_LO;
      ramp_x5 = {ramp_d[14:0], 2'b00} + 17'(ramp_d);
      if (stress >= RAMP_HI) begin
         boost_in = FULL_PCT;
         floor_in = HALF_PCT;
      end else if (stress <= RAMP_LO) begin
         boost_in = '0;
         floor_in = '0;
      end else begin
         boost_in = PCT_W'((ramp_x5 + 17'd1) >> 1);
         floor_in = FLOOR_W'((ramp_x5 + 17'd2) >> 2);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         asc6_ff    <= asc_in;
         prod_ff    <= prod_in;
         stress6_ff <= stress;
         boost6_ff  <= boost_in;
         floor6_ff  <= floor_in;
      end
   end

   // Stage 7: drop the fraction bits and estimate the quotient by 100.
   // Rounding up on a descending interval is a ceiling at each step.
   logic [IV_NUM_W-1:0] num_in, num_ff;
   logic [48:0]         div_prod;
   logic [IV_W-1:0]     q0_ff;
   logic                asc7_ff;
   logic [PCT_W-1:0]    stress7_ff, boost7_ff;
   logic [FLOOR_W-1:0]  floor7_ff;

   always_comb begin
      if (asc6_ff) begin
         num_in = IV_NUM_W'((32'(prod_ff) + 32'd255) >> FRAC_BITS)
                + (INTERVAL_DIV - IV_NUM_W'(1));
      end else begin
         num_in = IV_NUM_W'(prod_ff >> FRAC_BITS);
      end
      div_prod = 49'(num_in) * RECIP_100;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         num_ff     <= num_in;
         q0_ff      <= div_prod[32 +: IV_W];
         asc7_ff    <= asc6_ff;
         stress7_ff <= stress6_ff;
         boost7_ff  <= boost6_ff;
         floor7_ff  <= floor6_ff;
      end
   end

   // Stage 8: quotient correction and the interval; this is the output register.
   logic [IV_NUM_W-1:0] rem;
   logic [IV_W-1:0]     quo;
   result_type          result_ff, result_in;

   always_comb begin
      rem = num_ff - IV_NUM_W'(q0_ff) * INTERVAL_DIV;
      quo = q0_ff + IV_W'(rem >= INTERVAL_DIV);
      result_in.stress           = stress7_ff;
      result_in.poll_interval_ms = asc7_ff ? (csr.interval_max_ms - quo)
                                           : (csr.interval_max_ms + quo);
      result_in.perf_boost       = boost7_ff;
      result_in.cpu_floor        = floor7_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[7]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* hdl/load_stress_score_governor_unit.sv */
// Load stress governor. Each request carries one sample of system load
// readings (CPU, queue length, temperature, GPU, disk, memory and battery
// power) and yields one response with a stress score in 0..100, a poll
// interval between the two interval registers, a performance boost and a
// processor floor; percents are unsigned Q7.8. The unit keeps no state
// between samples, so it takes one request every clock cycle while the
// response port is not stalled, and returns each response through an
// eight-stage pipeline: term formation, weighted products, battery division
// fix-up and partial sum, memory/battery mix, rounding and clamp, interval
// product and ramp, division by 100, and the output register. Stages with a
// bubble keep filling while the response port is stalled. The weight and
// interval registers may only be written while no request is in flight.
module load_stress_score_governor_unit import lssg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   // cpu_util[14:0], queue_length[24:15], temperature[40:25], gpu_util[55:41],
   // disk_util[70:56], ram_util[85:71], battery_power[103:86]
   input  logic [103:0]         req_tdata,

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // stress[14:0], poll_interval_ms[30:15], perf_boost[45:31],
   // cpu_floor[59:46], zero fill[63:60]
   output logic [63:0]          rsp_tdata,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   // Configuration registers. Writes to an index beyond the list are dropped.
   csr_type csr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.weight_cpu      <= 16'd13107;
         csr_ff.weight_queue    <= 16'd13107;
         csr_ff.weight_thermal  <= 16'd13107;
         csr_ff.weight_gpu      <= 16'd6554;
         csr_ff.weight_disk     <= 16'd6554;
         csr_ff.interval_min_ms <= 16'd100;
         csr_ff.interval_max_ms <= 16'd1000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WEIGHT_CPU:     csr_ff.weight_cpu      <= csr_data;
            REG_WEIGHT_QUEUE:   csr_ff.weight_queue    <= csr_data;
            REG_WEIGHT_THERMAL: csr_ff.weight_thermal  <= csr_data;
            REG_WEIGHT_GPU:     csr_ff.weight_gpu      <= csr_data;
            REG_WEIGHT_DISK:    csr_ff.weight_disk     <= csr_data;
            REG_INTERVAL_MIN:   csr_ff.interval_min_ms <= csr_data;
            REG_INTERVAL_MAX:   csr_ff.interval_max_ms <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Pipeline valid bits. A stage loads when it is empty or when the stage
   // after it is moving, so bubbles collapse while the output is stalled.
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   pipe_ctrl_type         ctrl;

   always_comb begin
      ctrl.load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ctrl.load[k] = !valid_ff[k] || ctrl.load[k+1];
      end
      valid_in[0] = ctrl.load[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = ctrl.load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ctrl.load[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

   // Unpack the request.
   sample_type sample;

   assign sample.cpu_util      = req_tdata[14:0];
   assign sample.queue_length  = req_tdata[24:15];
   assign sample.temperature   = req_tdata[40:25];
   assign sample.gpu_util      = req_tdata[55:41];
   assign sample.disk_util     = req_tdata[70:56];
   assign sample.ram_util      = req_tdata[85:71];
   assign sample.battery_power = req_tdata[103:86];

   products_type     prod;
   logic [PCT_W-1:0] stress;
   result_type       result;

   lssg_terms u_terms (
      .clock    (clock),
      .ctrl     (ctrl),
      .csr      (csr_ff),
      .sample   (sample),
      .prod_out (prod)
   );

   lssg_score u_score (
      .clock  (clock),
      .ctrl   (ctrl),
      .prod   (prod),
      .stress (stress)
   );

   lssg_ramp u_ramp (
      .clock  (clock),
      .ctrl   (ctrl),
      .csr    (csr_ff),
      .stress (stress),
      .result (result)
   );

   assign rsp_tdata = {4'h0, result.cpu_floor, result.perf_boost,
                       result.poll_interval_ms, result.stress};

endmodule
